// ===== src/dbpk_pkg.sv =====
// ----------------------------------------------------------------------------
// dbpk_pkg
// Types and constants shared by the dual backlight PWM keeper modules.
// ----------------------------------------------------------------------------
package dbpk_pkg;

    // Request codes carried in the req_type field
    typedef enum logic [1:0] {
        REQ_LEVEL = 2'd0,
        REQ_KEEP  = 2'd1,
        REQ_TICK  = 2'd2
    } req_type_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PWM_PERIOD   = 4'd0,
        REG_EXPIRE_TICKS = 4'd1
    } cfg_reg_t;

    localparam int CFG_DATA_W = 16;
    localparam int TICKS_W    = 16;
    localparam int DUTY_OUT_W = 16;
    localparam int LEVEL_W    = 8;
    localparam int GAMMA_W    = 10;
    localparam int NUM_CH     = 2;

    // Divide by the gamma full scale (1000) through a reciprocal:
    // floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for every x below 2^26.
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;

    // Period premultiplied by the reciprocal
    localparam int PSCALE_W = CFG_DATA_W + RECIP_W;
    localparam int PROD_W   = PSCALE_W + GAMMA_W;
    localparam int QUOT_W   = PROD_W - RECIP_SHIFT;
    localparam logic [PSCALE_W-1:0] PSCALE_RESET = 43'd68719477000;
    localparam logic [TICKS_W-1:0]  EXPIRE_RESET = 16'd100;

    // Gamma curve, 1000 is full scale
    localparam logic [GAMMA_W-1:0] GAMMA_LUT [256] = '{
         10'd28,  10'd28,  10'd28,  10'd29,  10'd29,  10'd30,  10'd30,  10'd31,
         10'd31,  10'd31,  10'd32,  10'd32,  10'd33,  10'd33,  10'd34,  10'd34,
         10'd35,  10'd35,  10'd36,  10'd36,  10'd37,  10'd37,  10'd38,  10'd38,
         10'd39,  10'd39,  10'd40,  10'd41,  10'd41,  10'd42,  10'd42,  10'd43,
         10'd44,  10'd44,  10'd45,  10'd45,  10'd46,  10'd47,  10'd47,  10'd48,
         10'd49,  10'd49,  10'd50,  10'd51,  10'd52,  10'd52,  10'd53,  10'd54,
         10'd55,  10'd55,  10'd56,  10'd57,  10'd58,  10'd59,  10'd59,  10'd60,
         10'd61,  10'd62,  10'd63,  10'd64,  10'd65,  10'd66,  10'd67,  10'd67,
         10'd68,  10'd69,  10'd70,  10'd71,  10'd72,  10'd73,  10'd74,  10'd76,
         10'd77,  10'd78,  10'd79,  10'd80,  10'd81,  10'd82,  10'd83,  10'd85,
         10'd86,  10'd87,  10'd88,  10'd89,  10'd91,  10'd92,  10'd93,  10'd95,
         10'd96,  10'd97,  10'd99, 10'd100, 10'd102, 10'd103, 10'd104, 10'd106,
        10'd107, 10'd109, 10'd110, 10'd112, 10'd114, 10'd115, 10'd117, 10'd119,
        10'd120, 10'd122, 10'd124, 10'd125, 10'd127, 10'd129, 10'd131, 10'd133,
        10'd135, 10'd136, 10'd138, 10'd140, 10'd142, 10'd144, 10'd146, 10'd148,
        10'd151, 10'd153, 10'd155, 10'd157, 10'd159, 10'd161, 10'd164, 10'd166,
        10'd168, 10'd171, 10'd173, 10'd176, 10'd178, 10'd181, 10'd183, 10'd186,
        10'd188, 10'd191, 10'd194, 10'd197, 10'd199, 10'd202, 10'd205, 10'd208,
        10'd211, 10'd214, 10'd217, 10'd220, 10'd223, 10'd226, 10'd229, 10'd233,
        10'd236, 10'd239, 10'd243, 10'd246, 10'd250, 10'd253, 10'd257, 10'd260,
        10'd264, 10'd268, 10'd271, 10'd275, 10'd279, 10'd283, 10'd287, 10'd291,
        10'd295, 10'd299, 10'd304, 10'd308, 10'd312, 10'd317, 10'd321, 10'd326,
        10'd330, 10'd335, 10'd340, 10'd345, 10'd349, 10'd354, 10'd359, 10'd364,
        10'd370, 10'd375, 10'd380, 10'd385, 10'd391, 10'd396, 10'd402, 10'd408,
        10'd413, 10'd419, 10'd425, 10'd431, 10'd437, 10'd443, 10'd450, 10'd456,
        10'd462, 10'd469, 10'd476, 10'd482, 10'd489, 10'd496, 10'd503, 10'd510,
        10'd517, 10'd525, 10'd532, 10'd540, 10'd547, 10'd555, 10'd563, 10'd571,
        10'd579, 10'd587, 10'd595, 10'd604, 10'd612, 10'd621, 10'd629, 10'd638,
        10'd647, 10'd656, 10'd666, 10'd675, 10'd685, 10'd694, 10'd704, 10'd714,
        10'd724, 10'd734, 10'd745, 10'd755, 10'd766, 10'd777, 10'd788, 10'd799,
        10'd810, 10'd821, 10'd833, 10'd845, 10'd857, 10'd869, 10'd881, 10'd894,
        10'd906, 10'd919, 10'd932, 10'd945, 10'd958, 10'd972, 10'd986, 10'd1000
    };

    // Request item
    typedef struct packed {
        req_type_t           req_type;
        logic [LEVEL_W-1:0]  brightness;
        logic                unblanked;
        logic                panel;
        logic                keep_on;
    } req_item_t;

    // Result item
    typedef struct packed {
        logic                  pwm0_enable;
        logic [DUTY_OUT_W-1:0] pwm0_duty;
        logic                  pwm1_enable;
        logic [DUTY_OUT_W-1:0] pwm1_duty;
        logic                  keep0_state;
        logic                  keep1_state;
        logic                  timer0_busy;
        logic                  timer1_busy;
    } rsp_item_t;

    // Configuration held by the top level
    typedef struct packed {
        logic [PSCALE_W-1:0] pscale;
        logic [TICKS_W-1:0]  expire;
    } cfg_t;

endpackage

// ===== src/dual_backlight_pwm_keeper_top.sv =====
// ----------------------------------------------------------------------------
// dual_backlight_pwm_keeper_top
// Two backlight PWM channels driven from brightness, keep-on and tick items.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one item: a
//   brightness update, a keep-on flag write or a countdown tick. Each item
//   gives exactly one result on the rsp channel (rsp_valid / rsp_stall /
//   rsp_data) holding both channels' enable and duty, the keep-on flags and
//   the countdown busy bits after that item.
//   rsp_valid rises once the item moves from the input register into the result
//   register: the gamma lookup, one multiply by the scaled period and the state update land there.
//   Throughput is one item per cycle while rsp is not stalled.
//   A stalled result holds rsp_data; one more item may wait in the input
//   register, after which req_stall rises.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   pwm_period (index 0) or expire_ticks (index 1); other indexes are
//   ignored. cfg_ready is always high. Write only while no item is in flight.
//   Reset clears the channels, sets both keep-on flags, stops the countdowns,
//   and loads pwm_period 1000 and expire_ticks 100.
// ----------------------------------------------------------------------------
module dual_backlight_pwm_keeper_top #(
    parameter int PERIOD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  dbpk_pkg::req_item_t                 req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output dbpk_pkg::rsp_item_t                 rsp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dbpk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dbpk_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DUTY_W = (PERIOD_BITS < dbpk_pkg::DUTY_OUT_W) ? PERIOD_BITS
                                                                  : dbpk_pkg::DUTY_OUT_W;

    dbpk_pkg::req_item_t req_reg;
    logic                req_valid_reg;
    dbpk_pkg::rsp_item_t rsp_reg;
    logic                rsp_valid_reg;
    dbpk_pkg::cfg_t      cfg_reg;
    dbpk_pkg::rsp_item_t result;
    logic                advance;
    logic                fire;
    logic                accept;

    // Handshake: move the held item into the result register when it is free
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = req_valid_reg && advance;
    assign req_stall = req_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign cfg_ready = 1'b1;

    // Hold the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_data;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= result;
        end
    end

    // Configuration: keep the period premultiplied by the 1/1000 reciprocal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pscale <= dbpk_pkg::PSCALE_RESET;
            cfg_reg.expire <= dbpk_pkg::EXPIRE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == dbpk_pkg::REG_PWM_PERIOD)
            begin
                cfg_reg.pscale <= dbpk_pkg::PSCALE_W'(cfg_data) *
                                  dbpk_pkg::PSCALE_W'(dbpk_pkg::RECIP);
            end
            else if (cfg_index == dbpk_pkg::REG_EXPIRE_TICKS)
            begin
                cfg_reg.expire <= cfg_data;
            end
        end
    end

    dbpk_core #(
        .DUTY_W (DUTY_W)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (req_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

endmodule

// ===== src/dbpk_duty.sv =====
// ----------------------------------------------------------------------------
// dbpk_duty
// Duty from level: floor(period * gamma[level] / 1000), masked to DUTY_W bits.
// ----------------------------------------------------------------------------
module dbpk_duty #(
    parameter int DUTY_W = 16
) (
    input  logic [dbpk_pkg::LEVEL_W-1:0]  level,
    input  logic [dbpk_pkg::PSCALE_W-1:0] pscale,
    output logic [DUTY_W-1:0]             duty
);

    logic [dbpk_pkg::GAMMA_W-1:0] gamma;
    logic [dbpk_pkg::PROD_W-1:0]  prod;
    logic [dbpk_pkg::QUOT_W-1:0]  quot;

    // Look up gamma, scale the premultiplied period, drop the fraction
    always_comb
    begin
        gamma = dbpk_pkg::GAMMA_LUT[level];
        prod  = dbpk_pkg::PROD_W'(pscale) * dbpk_pkg::PROD_W'(gamma);
        quot  = prod[dbpk_pkg::PROD_W-1:dbpk_pkg::RECIP_SHIFT];
        duty  = quot[DUTY_W-1:0];
    end

endmodule

// ===== src/dbpk_core.sv =====
// ----------------------------------------------------------------------------
// dbpk_core
// Channel state, keep-on countdowns and PWM update for one item per cycle on which fire is high.
// ----------------------------------------------------------------------------
module dbpk_core #(
    parameter int DUTY_W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  dbpk_pkg::req_item_t item,
    input  dbpk_pkg::cfg_t      cfg,
    output dbpk_pkg::rsp_item_t result
);

    localparam int NCH = dbpk_pkg::NUM_CH;

    logic [dbpk_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic                         unblank_reg, unblank_next;
    logic [NCH-1:0]               active_reg, active_next;
    logic [DUTY_W-1:0]            duty_reg [NCH];
    logic [DUTY_W-1:0]            duty_next [NCH];
    logic [NCH-1:0]               keep_reg, keep_next;
    logic [NCH-1:0]               busy_reg, busy_next;
    logic [dbpk_pkg::TICKS_W-1:0] ticks_reg [NCH];
    logic [dbpk_pkg::TICKS_W-1:0] ticks_next [NCH];
    logic                         apply;
    logic [DUTY_W-1:0]            duty_calc;
    logic                         expire_on;

    assign expire_on = (cfg.expire != '0);

    // Take the new level and blank state on a brightness item
    always_comb
    begin
        level_next   = level_reg;
        unblank_next = unblank_reg;
        if (fire && (item.req_type == dbpk_pkg::REQ_LEVEL))
        begin
            level_next   = item.brightness;
            unblank_next = item.unblanked;
        end
    end

    dbpk_duty #(
        .DUTY_W (DUTY_W)
    ) u_duty (
        .level  (level_next),
        .pscale (cfg.pscale),
        .duty   (duty_calc)
    );

    // Flag and countdown updates, then the PWM update when one is due
    always_comb
    begin
        active_next = active_reg;
        duty_next   = duty_reg;
        keep_next   = keep_reg;
        busy_next   = busy_reg;
        ticks_next  = ticks_reg;
        apply       = 1'b0;
        if (fire)
        begin
            unique case (item.req_type)
                dbpk_pkg::REQ_LEVEL:
                begin
                    apply = 1'b1;
                end
                dbpk_pkg::REQ_KEEP:
                begin
                    for (int ch = 0; ch < NCH; ch++)
                    begin
                        if (item.panel == 1'(ch))
                        begin
                            if (keep_reg[ch] != item.keep_on)
                            begin
                                if (item.keep_on)
                                begin
                                    busy_next[ch] = 1'b0;
                                end
                                else if (expire_on && !busy_reg[ch])
                                begin
                                    ticks_next[ch] = cfg.expire;
                                    busy_next[ch]  = 1'b1;
                                end
                                keep_next[ch] = item.keep_on;
                                apply         = 1'b1;
                            end
                            else if (!item.keep_on)
                            begin
                                if (expire_on)
                                begin
                                    if (busy_reg[ch])
                                    begin
                                        ticks_next[ch] = cfg.expire;
                                    end
                                end
                                else
                                begin
                                    busy_next[ch] = 1'b0;
                                end
                                apply = 1'b1;
                            end
                        end
                    end
                end
                dbpk_pkg::REQ_TICK:
                begin
                    for (int ch = 0; ch < NCH; ch++)
                    begin
                        if (busy_reg[ch])
                        begin
                            if (ticks_reg[ch] > dbpk_pkg::TICKS_W'(1))
                            begin
                                ticks_next[ch] = ticks_reg[ch] - dbpk_pkg::TICKS_W'(1);
                            end
                            else
                            begin
                                ticks_next[ch] = '0;
                                keep_next[ch]  = 1'b1;
                                busy_next[ch]  = 1'b0;
                                apply          = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // Drive each channel from the final flags and stored level
            if (apply)
            begin
                for (int ch = 0; ch < NCH; ch++)
                begin
                    if (!unblank_next || (level_next == '0) || !keep_next[ch])
                    begin
                        if (active_reg[ch])
                        begin
                            duty_next[ch]   = '0;
                            active_next[ch] = 1'b0;
                        end
                    end
                    else
                    begin
                        duty_next[ch]   = duty_calc;
                        active_next[ch] = 1'b1;
                    end
                end
            end
        end
    end

    // Hold channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= '0;
            unblank_reg <= 1'b0;
            active_reg  <= '0;
            keep_reg    <= '1;
            busy_reg    <= '0;
            for (int ch = 0; ch < NCH; ch++)
            begin
                duty_reg[ch]  <= '0;
                ticks_reg[ch] <= '0;
            end
        end
        else
        begin
            level_reg   <= level_next;
            unblank_reg <= unblank_next;
            active_reg  <= active_next;
            keep_reg    <= keep_next;
            busy_reg    <= busy_next;
            duty_reg    <= duty_next;
            ticks_reg   <= ticks_next;
        end
    end

    // Report the state after this item
    always_comb
    begin
        result.pwm0_enable = active_next[0];
        result.pwm0_duty   = dbpk_pkg::DUTY_OUT_W'(duty_next[0]);
        result.pwm1_enable = active_next[1];
        result.pwm1_duty   = dbpk_pkg::DUTY_OUT_W'(duty_next[1]);
        result.keep0_state = keep_next[0];
        result.keep1_state = keep_next[1];
        result.timer0_busy = busy_next[0];
        result.timer1_busy = busy_next[1];
    end

endmodule
